### sv/jtq_pkg.sv
package jtq_pkg;

   // parameter defaults
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int DONE_DEPTH_DEF  = 16;
   localparam int ID_WIDTH_DEF    = 16;

   // fixed field widths
   localparam int OPCODE_W = 3;
   localparam int JOB_ID_W = 16;
   localparam int STATUS_W = 2;
   localparam int JSTATE_W = 2;
   localparam int RID_W    = 16;
   localparam int PEND_W   = 5;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_RAISE  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_START  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_FINISH = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_NOP    = 3'd7;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FALSE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // query answers
   localparam logic [JSTATE_W-1:0] JS_INVALID = 2'd0;
   localparam logic [JSTATE_W-1:0] JS_WAITING = 2'd1;
   localparam logic [JSTATE_W-1:0] JS_RUNNING = 2'd2;
   localparam logic [JSTATE_W-1:0] JS_DONE    = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [JOB_ID_W-1:0] job_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [JSTATE_W-1:0] job_state;
      logic [RID_W-1:0]    result_id;
      logic [PEND_W-1:0]   pending_count;
   } rsp_type;

endpackage

### sv/jtq_engine.sv
module jtq_engine #(
   parameter int QUEUE_DEPTH = jtq_pkg::QUEUE_DEPTH_DEF,
   parameter int DONE_DEPTH  = jtq_pkg::DONE_DEPTH_DEF,
   parameter int ID_WIDTH    = jtq_pkg::ID_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  jtq_pkg::req_type req_word,
   output logic             req_ready,
   output logic             res_valid,
   input  logic             res_take,
   output jtq_pkg::rsp_type res_word
);
   import jtq_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int DAW = (DONE_DEPTH > 1) ? $clog2(DONE_DEPTH) : 1;
   localparam int DCW = $clog2(DONE_DEPTH + 1);
   localparam int PW  = (QCW > DCW) ? QCW : DCW;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DSCAN, S_WSCAN, S_ROT, S_HEAD, S_RESP
   } state_type;

   state_type               state_ff, state_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [ID_WIDTH-1:0]     id_ff, id_in;
   logic [QCW-1:0]          cnt_ff, cnt_in;
   logic                    run_vld_ff, run_vld_in;
   logic [ID_WIDTH-1:0]     run_id_ff, run_id_in;
   logic [DONE_DEPTH-1:0]   dvalid_ff, dvalid_in;
   logic [DAW-1:0]          wp_ff, wp_in;
   logic [ID_WIDTH-1:0]     last_ff, last_in;
   logic [PW-1:0]           ptr_ff, ptr_in;
   logic                    rv_ff, rv_in;
   logic [PW-1:0]           ridx_ff, ridx_in;
   logic                    found_ff, found_in;
   logic [QAW-1:0]          pos_ff, pos_in;
   logic                    more_ff, more_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [JSTATE_W-1:0]     jstate_ff, jstate_in;
   logic [ID_WIDTH-1:0]     rid_ff, rid_in;

   // waiting list and done store memories
   logic [ID_WIDTH-1:0]     wmem [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]     dmem [DONE_DEPTH];
   logic [ID_WIDTH-1:0]     w_rdata_ff, d_rdata_ff;
   logic                    w_we, w_re, d_we, d_re;
   logic [QAW-1:0]          w_waddr, w_raddr;
   logic [DAW-1:0]          d_waddr, d_raddr;
   logic [ID_WIDTH-1:0]     w_wdata, d_wdata;

   // shared id comparator
   logic [ID_WIDTH-1:0]     cmp_a;
   logic                    cmp_hit;
   logic [ID_WIDTH-1:0]     nid;
   logic [QCW:0]            pend_sum;

   always_comb begin
      case (state_ff)
         S_EXEC:  cmp_a = run_id_ff;
         S_DSCAN: cmp_a = d_rdata_ff;
         default: cmp_a = w_rdata_ff;
      endcase
   end
   assign cmp_hit = (cmp_a == id_ff);

   always_comb begin
      nid = last_ff + ID_WIDTH'(1);
      if (nid == '0) begin
         nid = ID_WIDTH'(1);
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      cnt_in     = cnt_ff;
      run_vld_in = run_vld_ff;
      run_id_in  = run_id_ff;
      dvalid_in  = dvalid_ff;
      wp_in      = wp_ff;
      last_in    = last_ff;
      ptr_in     = ptr_ff;
      rv_in      = 1'b0;
      ridx_in    = ptr_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      more_in    = more_ff;
      status_in  = status_ff;
      jstate_in  = jstate_ff;
      rid_in     = rid_ff;
      w_we       = 1'b0;
      w_waddr    = '0;
      w_wdata    = '0;
      w_re       = 1'b0;
      w_raddr    = ptr_ff[QAW-1:0];
      d_we       = 1'b0;
      d_waddr    = wp_ff;
      d_wdata    = run_id_ff;
      d_re       = 1'b0;
      d_raddr    = ptr_ff[DAW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_word.opcode;
               id_in     = ID_WIDTH'(req_word.job_id);
               status_in = ST_FALSE;
               jstate_in = JS_INVALID;
               rid_in    = '0;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            ptr_in   = '0;
            found_in = 1'b0;
            state_in = S_RESP;
            case (op_ff)
               OP_PUSH: begin
                  if (cnt_ff == QCW'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     w_we      = 1'b1;
                     w_waddr   = cnt_ff[QAW-1:0];
                     w_wdata   = nid;
                     cnt_in    = cnt_ff + QCW'(1);
                     last_in   = nid;
                     rid_in    = nid;
                     status_in = ST_OK;
                  end
               end
               OP_REMOVE: begin
                  if (!(run_vld_ff && cmp_hit)) begin
                     state_in = S_DSCAN;
                  end
               end
               OP_QUERY: begin
                  if (run_vld_ff && cmp_hit) begin
                     jstate_in = JS_RUNNING;
                     status_in = ST_OK;
                  end else begin
                     state_in = S_DSCAN;
                  end
               end
               OP_RAISE: begin
                  state_in = S_WSCAN;
               end
               OP_START: begin
                  if (!run_vld_ff && cnt_ff != '0) begin
                     state_in = S_WSCAN;
                  end
               end
               OP_FINISH: begin
                  if (run_vld_ff) begin
                     d_we             = 1'b1;
                     dvalid_in[wp_ff] = 1'b1;
                     wp_in            = (wp_ff == DAW'(DONE_DEPTH - 1)) ? '0
                                                                        : wp_ff + DAW'(1);
                     run_vld_in       = 1'b0;
                     run_id_in        = '0;
                     status_in        = ST_OK;
                  end
               end
               OP_CLEAR: begin
                  cnt_in    = '0;
                  status_in = ST_OK;
               end
               default: begin
               end
            endcase
         end

         // one done entry per cycle, every matching entry
         S_DSCAN: begin
            if (ptr_ff < PW'(DONE_DEPTH)) begin
               d_re    = 1'b1;
               ptr_in  = ptr_ff + PW'(1);
               rv_in   = 1'b1;
               ridx_in = ptr_ff;
            end
            if (rv_ff && dvalid_ff[ridx_ff[DAW-1:0]] && cmp_hit) begin
               found_in = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  dvalid_in[ridx_ff[DAW-1:0]] = 1'b0;
               end
            end
            if (!rv_ff && ptr_ff >= PW'(DONE_DEPTH)) begin
               if (found_ff) begin
                  status_in = ST_OK;
                  if (op_ff == OP_QUERY) begin
                     jstate_in = JS_DONE;
                  end
                  state_in = S_RESP;
               end else begin
                  ptr_in   = '0;
                  state_in = S_WSCAN;
               end
            end
         end

         // one waiting entry per cycle, shifting down behind a removed or started entry
         S_WSCAN: begin
            if (ptr_ff < PW'(cnt_ff)) begin
               w_re    = 1'b1;
               ptr_in  = ptr_ff + PW'(1);
               rv_in   = 1'b1;
               ridx_in = ptr_ff;
            end
            if (rv_ff) begin
               case (op_ff)
                  OP_START: begin
                     if (ridx_ff == '0) begin
                        run_id_in = w_rdata_ff;
                     end else begin
                        w_we    = 1'b1;
                        w_waddr = ridx_ff[QAW-1:0] - QAW'(1);
                        w_wdata = w_rdata_ff;
                     end
                  end
                  OP_REMOVE: begin
                     if (found_ff) begin
                        w_we    = 1'b1;
                        w_waddr = ridx_ff[QAW-1:0] - QAW'(1);
                        w_wdata = w_rdata_ff;
                     end else if (cmp_hit) begin
                        found_in = 1'b1;
                     end
                  end
                  default: begin
                     if (!found_ff && cmp_hit) begin
                        found_in = 1'b1;
                        pos_in   = ridx_ff[QAW-1:0];
                     end
                  end
               endcase
            end
            if (!rv_ff && ptr_ff >= PW'(cnt_ff)) begin
               state_in = S_RESP;
               case (op_ff)
                  OP_START: begin
                     cnt_in     = cnt_ff - QCW'(1);
                     run_vld_in = 1'b1;
                     rid_in     = run_id_ff;
                     status_in  = ST_OK;
                  end
                  OP_REMOVE: begin
                     if (found_ff) begin
                        cnt_in = cnt_ff - QCW'(1);
                     end
                     status_in = ST_OK;
                  end
                  OP_QUERY: begin
                     if (found_ff) begin
                        jstate_in = JS_WAITING;
                     end
                     status_in = ST_OK;
                  end
                  OP_RAISE: begin
                     if (found_ff) begin
                        if (pos_ff == '0) begin
                           status_in = ST_OK;
                        end else begin
                           ptr_in   = PW'(pos_ff) - PW'(1);
                           more_in  = 1'b1;
                           state_in = S_ROT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // move entries ahead of the raised one up by one index, highest index first
         S_ROT: begin
            if (more_ff) begin
               w_re    = 1'b1;
               rv_in   = 1'b1;
               ridx_in = ptr_ff;
               if (ptr_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - PW'(1);
               end
            end
            if (rv_ff) begin
               w_we    = 1'b1;
               w_waddr = ridx_ff[QAW-1:0] + QAW'(1);
               w_wdata = w_rdata_ff;
            end
            if (!rv_ff && !more_ff) begin
               state_in = S_HEAD;
            end
         end

         S_HEAD: begin
            w_we      = 1'b1;
            w_waddr   = '0;
            w_wdata   = id_ff;
            status_in = ST_OK;
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      id_ff     <= id_in;
      ptr_ff    <= ptr_in;
      ridx_ff   <= ridx_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      jstate_ff <= jstate_in;
      rid_ff    <= rid_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         run_vld_ff <= 1'b0;
         run_id_ff  <= '0;
         dvalid_ff  <= '0;
         wp_ff      <= '0;
         last_ff    <= '0;
         rv_ff      <= 1'b0;
         found_ff   <= 1'b0;
         more_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         run_vld_ff <= run_vld_in;
         run_id_ff  <= run_id_in;
         dvalid_ff  <= dvalid_in;
         wp_ff      <= wp_in;
         last_ff    <= last_in;
         rv_ff      <= rv_in;
         found_ff   <= found_in;
         more_ff    <= more_in;
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      if (w_re) begin
         w_rdata_ff <= wmem[w_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         dmem[d_waddr] <= d_wdata;
      end
      if (d_re) begin
         d_rdata_ff <= dmem[d_raddr];
      end
   end

   assign pend_sum  = {1'b0, cnt_ff} + (QCW + 1)'(run_vld_ff);
   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);

   always_comb begin
      res_word.status        = status_ff;
      res_word.job_state     = jstate_ff;
      res_word.result_id     = RID_W'(rid_ff);
      res_word.pending_count = PEND_W'(pend_sum);
   end

endmodule

### sv/job_tracking_queue_core.sv
// channel   dir  handshake                 word
// req_      in   req_valid / req_stall     req_type: opcode, job_id
// rsp_      out  rsp_valid / rsp_stall     rsp_type: status, job_state, result_id,
//                                          pending_count
//
// push, finish, clear and no-op: S_EXEC, then S_RESP, then the output register
// start next: S_EXEC, then a scan of the waiting list; raise adds a rotate pass and a head write
// remove and query: a done-store scan, then a waiting-list scan if not found, each reading
// one entry a cycle from the id memories into the single shared comparator
// synchronous reset clears all control state at once, no clearing pass
// a new word is taken while a result still waits in the output register; a finished
// result is held in the engine until that register frees up
module job_tracking_queue_core #(
   parameter int QUEUE_DEPTH = jtq_pkg::QUEUE_DEPTH_DEF,
   parameter int DONE_DEPTH  = jtq_pkg::DONE_DEPTH_DEF,
   parameter int ID_WIDTH    = jtq_pkg::ID_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jtq_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jtq_pkg::rsp_type rsp_word
);
   import jtq_pkg::*;

   logic    eng_ready;
   logic    res_valid;
   logic    res_take;
   rsp_type res_word;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_word_ff;

   // sequencer, id memories and the shared comparator
   jtq_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DONE_DEPTH  (DONE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_ready (eng_ready),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_word  (res_word)
   );

   // engine takes a word only when idle
   assign req_stall = !eng_ready;

   // move the result when the output register is empty or being drained
   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_word_ff <= res_word;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### sv/jtq_checker.sv
module jtq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input jtq_pkg::rsp_type rsp_word
);
   import jtq_pkg::*;

   // the engine is busy in the cycle after taking a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // an issued id or a query answer only comes with success
   a_answer_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.result_id != '0 || rsp_word.job_state != JS_INVALID)
      |-> rsp_word.status == ST_OK)
      else $error("answer without success status");

   // idle and empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind job_tracking_queue_core jtq_checker u_jtq_checker (.*);
